// ----- src/pmp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmp_pkg
// shared types, register codes and the phase schedule of the pump sequencer
// ----------------------------------------------------------------------------
package pmp_pkg;

    localparam int ADC_BITS       = 10;
    localparam int SCHEDULE_STEPS = 26;
    localparam int LEVEL_BITS     = 5;
    localparam int INDEX_BITS     = 5;
    localparam int PTIMER_BITS    = 10;
    localparam int DEB_BITS       = 3;
    localparam int CFG_DATA_BITS  = 10;
    localparam int CFG_IDX_BITS   = 3;

    // schedule constants
    localparam logic [LEVEL_BITS-1:0]  LEVEL_FULL  = LEVEL_BITS'(24);
    localparam logic [LEVEL_BITS-1:0]  LEVEL_SOFT  = LEVEL_BITS'(5);
    localparam logic [PTIMER_BITS-1:0] TIME_KICK   = PTIMER_BITS'(3);
    localparam logic [PTIMER_BITS-1:0] TIME_SOFT   = PTIMER_BITS'(597);
    localparam logic [PTIMER_BITS-1:0] TIME_DRIVE  = PTIMER_BITS'(120);
    localparam logic [PTIMER_BITS-1:0] TIME_REST   = PTIMER_BITS'(60);

    // register reset values
    localparam logic [ADC_BITS-1:0]   NO_LOAD_TH_RST  = ADC_BITS'(175);
    localparam logic [ADC_BITS-1:0]   DEAD_TH_RST     = ADC_BITS'(40);
    localparam logic [DEB_BITS-1:0]   LOAD_DEB_RST    = DEB_BITS'(5);
    localparam logic [DEB_BITS-1:0]   DEAD_DEB_RST    = DEB_BITS'(5);
    localparam logic [INDEX_BITS-1:0] RETRY_LIMIT_RST = INDEX_BITS'(25);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NO_LOAD_TH = 3'd0,
        CFG_DEAD_TH    = 3'd1,
        CFG_LOAD_DEB   = 3'd2,
        CFG_DEAD_DEB   = 3'd3,
        CFG_RETRY_LIM  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_ON   = 2'd1,
        FUNC_OFF  = 2'd2,
        FUNC_NOP  = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]          func;
        logic [ADC_BITS-1:0] feedback_adc;
    } req_word_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] drive_level;
        logic                  commanded_on;
        logic                  phase_active;
        logic                  fault;
        logic                  load_present;
    } rsp_word_t;

    typedef struct packed {
        logic [ADC_BITS-1:0]   no_load_threshold;
        logic [ADC_BITS-1:0]   dead_threshold;
        logic [DEB_BITS-1:0]   load_debounce;
        logic [DEB_BITS-1:0]   dead_debounce;
        logic [INDEX_BITS-1:0] retry_limit;
    } cfg_regs_t;

    // drive level of a schedule phase, rest beyond the end
    function automatic logic [LEVEL_BITS-1:0] sched_level(
        input logic [INDEX_BITS-1:0] idx,
        input int                    steps
    );
        logic [LEVEL_BITS-1:0] lvl;
        if (int'(idx) >= steps)
            lvl = '0;
        else if (idx == INDEX_BITS'(0))
            lvl = LEVEL_FULL;
        else if (idx == INDEX_BITS'(1))
            lvl = LEVEL_SOFT;
        else if (idx[0])
            lvl = LEVEL_FULL;
        else
            lvl = '0;
        return lvl;
    endfunction

    // duration of a schedule phase in ticks, zero beyond the end
    function automatic logic [PTIMER_BITS-1:0] sched_time(
        input logic [INDEX_BITS-1:0] idx,
        input int                    steps
    );
        logic [PTIMER_BITS-1:0] t;
        if (int'(idx) >= steps)
            t = '0;
        else if (idx == INDEX_BITS'(0))
            t = TIME_KICK;
        else if (idx == INDEX_BITS'(1))
            t = TIME_SOFT;
        else if (idx[0])
            t = TIME_DRIVE;
        else
            t = TIME_REST;
        return t;
    endfunction

endpackage

// ----- src/pmp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmp_core
// sequencer state and single-pass update for one command word
// ----------------------------------------------------------------------------
module pmp_core #(
    parameter int STEPS = pmp_pkg::SCHEDULE_STEPS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  pmp_pkg::req_word_t req,
    input  pmp_pkg::cfg_regs_t cfg,
    output pmp_pkg::rsp_word_t rsp
);
    import pmp_pkg::*;

    localparam logic [INDEX_BITS-1:0] LIM_MAX = INDEX_BITS'(STEPS - 1);

    logic                   run_reg, run_next;
    logic [LEVEL_BITS-1:0]  plevel_reg, plevel_next;
    logic [INDEX_BITS-1:0]  pindex_reg, pindex_next;
    logic [PTIMER_BITS-1:0] ptimer_reg, ptimer_next;
    logic                   err_reg, err_next;
    logic                   lflag_reg, lflag_next;
    logic [DEB_BITS-1:0]    ltimer_reg, ltimer_next;
    logic                   dflag_reg, dflag_next;
    logic [DEB_BITS-1:0]    dtimer_reg, dtimer_next;
    logic [LEVEL_BITS-1:0]  drive_reg, drive_next;

    logic [INDEX_BITS-1:0]  lim;
    logic                   df_a;
    logic [DEB_BITS-1:0]    dt_a;
    logic [DEB_BITS-1:0]    lt_a;

    always_comb
    begin
        run_next    = run_reg;
        plevel_next = plevel_reg;
        pindex_next = pindex_reg;
        ptimer_next = ptimer_reg;
        err_next    = err_reg;
        lflag_next  = lflag_reg;
        ltimer_next = ltimer_reg;
        dflag_next  = dflag_reg;
        dtimer_next = dtimer_reg;
        drive_next  = drive_reg;
        lim         = (cfg.retry_limit > LIM_MAX) ? LIM_MAX : cfg.retry_limit;
        df_a        = dflag_reg;
        dt_a        = dtimer_reg;
        lt_a        = ltimer_reg;

        unique case (func_t'(req.func))
            FUNC_TICK:
            begin
                if (!run_reg || err_reg)
                begin
                    drive_next  = '0;
                    lflag_next  = 1'b1;
                    ltimer_next = cfg.load_debounce;
                    dflag_next  = 1'b1;
                    dtimer_next = cfg.dead_debounce;
                end
                else if (ptimer_reg == '0)
                begin
                    // load next phase
                    plevel_next = sched_level(pindex_reg, STEPS);
                    ptimer_next = sched_time(pindex_reg, STEPS);
                    pindex_next = pindex_reg + INDEX_BITS'(1);
                    if (pindex_next > lim)
                        err_next = 1'b1;
                end
                else
                begin
                    ptimer_next = ptimer_reg - PTIMER_BITS'(1);
                    if (plevel_reg != '0)
                    begin
                        // dead pump gets one tick of forced power-off
                        if (dflag_reg)
                        begin
                            df_a       = 1'b0;
                            dt_a       = cfg.dead_debounce;
                            drive_next = '0;
                        end
                        else
                        begin
                            drive_next = plevel_reg;
                        end
                        // dead debounce
                        if (req.feedback_adc < cfg.dead_threshold)
                        begin
                            if (dt_a != '0)
                                dtimer_next = dt_a - DEB_BITS'(1);
                            else
                            begin
                                dtimer_next = dt_a;
                                df_a        = 1'b1;
                            end
                            dflag_next = df_a;
                            if (dt_a != '0)
                                dflag_next = df_a;
                        end
                        else
                        begin
                            dflag_next  = 1'b0;
                            dtimer_next = cfg.dead_debounce;
                        end
                        // load debounce
                        if (req.feedback_adc < cfg.no_load_threshold)
                        begin
                            lt_a = (ltimer_reg != '0) ? ltimer_reg - DEB_BITS'(1) : ltimer_reg;
                            ltimer_next = lt_a;
                            if (lt_a == '0)
                                lflag_next = 1'b0;
                        end
                        else
                        begin
                            lflag_next  = 1'b1;
                            ltimer_next = cfg.load_debounce;
                        end
                    end
                    else
                    begin
                        drive_next = '0;
                    end
                end
            end
            FUNC_ON:
            begin
                run_next = 1'b1;
            end
            FUNC_OFF:
            begin
                run_next    = 1'b0;
                plevel_next = '0;
                pindex_next = '0;
                ptimer_next = '0;
                drive_next  = '0;
            end
            FUNC_NOP:
            begin
                run_next = run_reg;
            end
            default:
            begin
                run_next = run_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            plevel_reg <= '0;
            pindex_reg <= '0;
            ptimer_reg <= '0;
            err_reg    <= 1'b0;
            lflag_reg  <= 1'b0;
            ltimer_reg <= LOAD_DEB_RST;
            dflag_reg  <= 1'b0;
            dtimer_reg <= '0;
            drive_reg  <= '0;
        end
        else if (step_en)
        begin
            run_reg    <= run_next;
            plevel_reg <= plevel_next;
            pindex_reg <= pindex_next;
            ptimer_reg <= ptimer_next;
            err_reg    <= err_next;
            lflag_reg  <= lflag_next;
            ltimer_reg <= ltimer_next;
            dflag_reg  <= dflag_next;
            dtimer_reg <= dtimer_next;
            drive_reg  <= drive_next;
        end
    end

    // result reflects the state after this word
    assign rsp.drive_level  = drive_next;
    assign rsp.commanded_on = run_next;
    assign rsp.phase_active = (plevel_next != '0);
    assign rsp.fault        = err_next;
    assign rsp.load_present = lflag_next;

endmodule

// ----- src/pump_retry_sequencer_with_load_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_retry_sequencer_with_load_check
// tick-driven pump schedule with retry fault and load / dead debounce
// ----------------------------------------------------------------------------
// usage
//   req channel: one word per event (tick with feedback sample, turn on,
//   turn off). a word is taken at a clock edge with req_valid high and
//   req_stall low.
//   rsp channel: exactly one word per request, in order, showing drive level,
//   run command, phase activity, sticky fault and load flag after the event.
//   cfg port: write-only, cfg_we with cfg_index and cfg_data; index values
//   past the register list are ignored. write only while the block is idle.
// pipeline and throughput
//   a request is held in the input register, is evaluated in a single
//   combinational pass against the sequencer state and lands in the output
//   register, whose valid flag drives rsp_valid. one word per cycle is
//   sustained while rsp_stall is low, set by the single state update path.
// reset
//   rst_n clears both pipeline registers, the sequencer state and restores
//   the register defaults; the pump is off and no fault is pending.
// stall
//   while rsp_stall holds the output word, the input register still drains
//   into it once it empties; req_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module pump_retry_sequencer_with_load_check #(
    parameter int SCHEDULE_STEPS = pmp_pkg::SCHEDULE_STEPS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                req_valid,
    output logic                                req_stall,
    input  pmp_pkg::req_word_t                  req,
    // response channel
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output pmp_pkg::rsp_word_t                  rsp,
    // configuration port
    input  logic                                cfg_we,
    input  logic [pmp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [pmp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import pmp_pkg::*;

    // configuration registers
    cfg_regs_t cfg_reg;

    // input stage
    logic      s1_valid_reg;
    req_word_t s1_word_reg;

    // output stage
    logic      out_valid_reg;
    rsp_word_t out_word_reg;

    logic      out_free;
    logic      s1_move;
    logic      req_take;
    rsp_word_t core_rsp;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign s1_move   = s1_valid_reg && out_free;
    assign req_stall = s1_valid_reg && !out_free;
    assign req_take  = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.no_load_threshold <= NO_LOAD_TH_RST;
            cfg_reg.dead_threshold    <= DEAD_TH_RST;
            cfg_reg.load_debounce     <= LOAD_DEB_RST;
            cfg_reg.dead_debounce     <= DEAD_DEB_RST;
            cfg_reg.retry_limit       <= RETRY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NO_LOAD_TH: cfg_reg.no_load_threshold <= cfg_data[ADC_BITS-1:0];
                CFG_DEAD_TH:    cfg_reg.dead_threshold    <= cfg_data[ADC_BITS-1:0];
                CFG_LOAD_DEB:   cfg_reg.load_debounce     <= cfg_data[DEB_BITS-1:0];
                CFG_DEAD_DEB:   cfg_reg.dead_debounce     <= cfg_data[DEB_BITS-1:0];
                CFG_RETRY_LIM:  cfg_reg.retry_limit       <= cfg_data[INDEX_BITS-1:0];
                default:        cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // input register: loads whenever it is empty or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_valid_reg || s1_move)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            s1_word_reg <= req;
    end

    // sequencer state advances exactly when a word moves to the output stage
    pmp_core #(
        .STEPS (SCHEDULE_STEPS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (s1_move),
        .req     (s1_word_reg),
        .cfg     (cfg_reg),
        .rsp     (core_rsp)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
            out_word_reg <= core_rsp;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_word_reg;

endmodule

// ----- test/pump_retry_sequencer_with_load_check_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_retry_sequencer_with_load_check_tb
// self-checking bench for the tick-driven pump sequencer
// ----------------------------------------------------------------------------
// a short opening table walks the pump through turn on, the kick phase, the
// soft-start phase, turn off, the forced-off tick after a dead pump and the
// debounce of both feedback flags. random segments follow, each with its own
// register setting, and one long segment runs the schedule into the sticky
// fault. every status word is checked field by field against typed values or
// an in-bench model of the sequencer. both channels idle and stall at random.
// ----------------------------------------------------------------------------
module pump_retry_sequencer_with_load_check_tb;

    import pmp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // flag in the opening table: status typed in by hand or taken from the model
    localparam logic TYPED   = 1'b1;
    localparam logic PREDICT = 1'b0;

    // hand-typed status words: drive, commanded, phase active, fault, load
    localparam rsp_word_t STATUS_OFF      = {5'd0, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam rsp_word_t STATUS_ON_IDLE  = {5'd0, 1'b1, 1'b0, 1'b0, 1'b1};
    localparam rsp_word_t STATUS_KICK_SET = {5'd0, 1'b1, 1'b1, 1'b0, 1'b1};
    localparam rsp_word_t NO_STATUS       = '0;

    typedef struct packed {
        func_t               func;
        logic [ADC_BITS-1:0] adc;
        logic                typed;
        rsp_word_t           status;
    } opening_row_t;

    // opening table, runs under the reset register values
    opening_row_t opening_rows [25] = '{
        '{FUNC_TICK, 10'd0,    TYPED,   STATUS_OFF},      // tick while off
        '{FUNC_NOP,  10'd1023, TYPED,   STATUS_OFF},      // unused code, no change
        '{FUNC_ON,   10'd0,    TYPED,   STATUS_ON_IDLE},
        '{FUNC_TICK, 10'd1023, TYPED,   STATUS_KICK_SET}, // kick phase loaded
        '{FUNC_TICK, 10'd1023, PREDICT, NO_STATUS},       // dead flag forces off
        '{FUNC_TICK, 10'd1023, PREDICT, NO_STATUS},
        '{FUNC_TICK, 10'd0,    PREDICT, NO_STATUS},
        '{FUNC_TICK, 10'd0,    PREDICT, NO_STATUS},       // soft-start loaded
        '{FUNC_TICK, 10'd39,   PREDICT, NO_STATUS},       // just under dead level
        '{FUNC_TICK, 10'd40,   PREDICT, NO_STATUS},       // on the dead level
        '{FUNC_TICK, 10'd174,  PREDICT, NO_STATUS},       // just under no-load level
        '{FUNC_TICK, 10'd175,  PREDICT, NO_STATUS},       // on the no-load level
        '{FUNC_OFF,  10'd1023, TYPED,   STATUS_OFF},
        '{FUNC_TICK, 10'd512,  TYPED,   STATUS_OFF},
        '{FUNC_ON,   10'd0,    TYPED,   STATUS_ON_IDLE},
        '{FUNC_TICK, 10'd0,    PREDICT, NO_STATUS},       // zero feedback from here:
        '{FUNC_TICK, 10'd0,    PREDICT, NO_STATUS},       // load flag drops, dead flag
        '{FUNC_TICK, 10'd0,    PREDICT, NO_STATUS},       // sets and forces one tick off
        '{FUNC_TICK, 10'd0,    PREDICT, NO_STATUS},
        '{FUNC_TICK, 10'd0,    PREDICT, NO_STATUS},
        '{FUNC_TICK, 10'd0,    PREDICT, NO_STATUS},
        '{FUNC_TICK, 10'd0,    PREDICT, NO_STATUS},
        '{FUNC_TICK, 10'd0,    PREDICT, NO_STATUS},
        '{FUNC_TICK, 10'd0,    PREDICT, NO_STATUS},
        '{FUNC_NOP,  10'd682,  PREDICT, NO_STATUS}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;

    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // status words still owed by the block, oldest first
    rsp_word_t status_due [$];

    int errors = 0;
    int cycle_count = 0;
    int words_sent = 0;
    int words_checked = 0;
    int full_drive_seen = 0;
    int soft_drive_seen = 0;
    int load_lost_seen = 0;
    int fault_seen = 0;

    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int rx_wait = 0;
    int adc_band = 3;

    // sequencer model: register copy and state, reset values
    cfg_regs_t             model_cfg = '{NO_LOAD_TH_RST, DEAD_TH_RST, LOAD_DEB_RST,
                                         DEAD_DEB_RST, RETRY_LIMIT_RST};
    logic                  run_on = 1'b0;
    logic [LEVEL_BITS-1:0] cur_level = '0;
    logic [INDEX_BITS-1:0] cur_index = '0;
    logic [PTIMER_BITS-1:0] phase_ticks = '0;
    logic                  fault_sticky = 1'b0;
    logic                  load_seen = 1'b0;
    logic [DEB_BITS-1:0]   load_hold = DEB_BITS'(5);
    logic                  dead_seen = 1'b0;
    logic [DEB_BITS-1:0]   dead_hold = '0;
    logic [LEVEL_BITS-1:0] drive_out = '0;

    pump_retry_sequencer_with_load_check i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // advance the sequencer model by one word and return the status after it
    function automatic rsp_word_t pump_next_status(input req_word_t w);
        rsp_word_t             st;
        logic [INDEX_BITS-1:0] lim;
        case (func_t'(w.func))
            FUNC_TICK:
            begin
                if (!run_on || fault_sticky)
                begin
                    // pump stopped: flags parked at "loaded" and "dead"
                    drive_out = '0;
                    load_seen = 1'b1;
                    load_hold = model_cfg.load_debounce;
                    dead_seen = 1'b1;
                    dead_hold = model_cfg.dead_debounce;
                end
                else if (phase_ticks == '0)
                begin
                    // next phase of the schedule, drive left as it is
                    if (int'(cur_index) >= SCHEDULE_STEPS)
                    begin
                        cur_level   = '0;
                        phase_ticks = '0;
                    end
                    else
                    begin
                        case (cur_index)
                            INDEX_BITS'(0):
                            begin
                                cur_level   = LEVEL_FULL;
                                phase_ticks = TIME_KICK;
                            end
                            INDEX_BITS'(1):
                            begin
                                cur_level   = LEVEL_SOFT;
                                phase_ticks = TIME_SOFT;
                            end
                            default:
                            begin
                                cur_level   = cur_index[0] ? LEVEL_FULL : '0;
                                phase_ticks = cur_index[0] ? TIME_DRIVE : TIME_REST;
                            end
                        endcase
                    end
                    cur_index = cur_index + 1'b1;
                    lim = (int'(model_cfg.retry_limit) > SCHEDULE_STEPS - 1)
                        ? INDEX_BITS'(SCHEDULE_STEPS - 1) : model_cfg.retry_limit;
                    if (cur_index > lim)
                        fault_sticky = 1'b1;
                end
                else
                begin
                    phase_ticks = phase_ticks - 1'b1;
                    if (cur_level != '0)
                    begin
                        // a dead pump gets one tick with the drive off
                        if (dead_seen)
                        begin
                            dead_seen = 1'b0;
                            dead_hold = model_cfg.dead_debounce;
                            drive_out = '0;
                        end
                        else
                            drive_out = cur_level;
                        if (w.feedback_adc < model_cfg.dead_threshold)
                        begin
                            if (dead_hold != '0)
                                dead_hold = dead_hold - 1'b1;
                            else
                                dead_seen = 1'b1;
                        end
                        else
                        begin
                            dead_seen = 1'b0;
                            dead_hold = model_cfg.dead_debounce;
                        end
                        if (w.feedback_adc < model_cfg.no_load_threshold)
                        begin
                            if (load_hold != '0)
                                load_hold = load_hold - 1'b1;
                            if (load_hold == '0)
                                load_seen = 1'b0;
                        end
                        else
                        begin
                            load_seen = 1'b1;
                            load_hold = model_cfg.load_debounce;
                        end
                    end
                    else
                        drive_out = '0;
                end
            end
            FUNC_ON:
                run_on = 1'b1;
            FUNC_OFF:
            begin
                // fault and feedback flags are kept, run, schedule and drive restart
                run_on      = 1'b0;
                cur_level   = '0;
                cur_index   = '0;
                phase_ticks = '0;
                drive_out   = '0;
            end
            default:
                ;
        endcase
        st.drive_level  = drive_out;
        st.commanded_on = run_on;
        st.phase_active = (cur_level != '0);
        st.fault        = fault_sticky;
        st.load_present = load_seen;
        return st;
    endfunction

    // feedback sample, drawn in streaks around the current thresholds
    function automatic logic [ADC_BITS-1:0] pick_adc();
        int lo;
        int hi;
        if ($urandom_range(0, 15) == 0)
            adc_band = $urandom_range(0, 3);
        lo = 0;
        hi = 1023;
        case (adc_band)
            0: hi = int'(model_cfg.dead_threshold) - 1;
            1:
            begin
                lo = int'(model_cfg.dead_threshold);
                hi = int'(model_cfg.no_load_threshold) - 1;
            end
            2: lo = int'(model_cfg.no_load_threshold);
            default: ;
        endcase
        if (hi < lo)
        begin
            lo = 0;
            hi = 1023;
        end
        return ADC_BITS'($urandom_range(lo, hi));
    endfunction

    // offer one word, wait for the handshake, then log the status it owes
    task automatic send_word(input func_t f, input logic [ADC_BITS-1:0] adc,
                             input logic typed, input rsp_word_t typed_status);
        req_word_t w;
        rsp_word_t predicted;
        int        gap;
        w.func         = f;
        w.feedback_adc = adc;
        if ($urandom_range(0, 31) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall);
        predicted = pump_next_status(w);
        status_due.push_back(typed ? typed_status : predicted);
        words_sent++;
    endtask

    // stop sending and wait until every owed status word is in
    task automatic drain();
        req_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(val);
        @(posedge clk);
        case (idx)
            CFG_NO_LOAD_TH: model_cfg.no_load_threshold = ADC_BITS'(val);
            CFG_DEAD_TH:    model_cfg.dead_threshold    = ADC_BITS'(val);
            CFG_LOAD_DEB:   model_cfg.load_debounce     = DEB_BITS'(val);
            CFG_DEAD_DEB:   model_cfg.dead_debounce     = DEB_BITS'(val);
            CFG_RETRY_LIM:  model_cfg.retry_limit       = INDEX_BITS'(val);
            default: ;
        endcase
    endtask

    task automatic program_regs(input int no_load, input int dead, input int load_deb,
                                input int dead_deb, input int retry);
        write_reg(CFG_NO_LOAD_TH, no_load);
        write_reg(CFG_DEAD_TH, dead);
        write_reg(CFG_LOAD_DEB, load_deb);
        write_reg(CFG_DEAD_DEB, dead_deb);
        write_reg(CFG_RETRY_LIM, retry);
        cfg_we <= 1'b0;
    endtask

    // one run of the pump: off, on, then mostly ticks with a share of
    // other commands mixed in (noise in percent)
    task automatic run_pump(input int count, input int noise, input bit allow_off);
        int    k;
        func_t f;
        send_word(FUNC_OFF, pick_adc(), PREDICT, NO_STATUS);
        send_word(FUNC_ON, pick_adc(), PREDICT, NO_STATUS);
        for (k = 2; k < count; k++)
        begin
            f = FUNC_TICK;
            if ($urandom_range(0, 99) < noise)
            begin
                case ($urandom_range(0, 2))
                    0: f = FUNC_ON;
                    1: f = allow_off ? FUNC_OFF : FUNC_NOP;
                    default: f = FUNC_NOP;
                endcase
            end
            send_word(f, pick_adc(), PREDICT, NO_STATUS);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // status side: check each accepted word, then draw the next stall
    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (status_due.size() == 0)
            begin
                errors++;
                $display("%0t ns: status word with none owed, expected nothing, actual %h",
                         $time, rsp);
            end
            else
            begin
                want = status_due.pop_front();
                check_field("drive_level", 32'(want.drive_level), 32'(rsp.drive_level));
                check_field("commanded_on", 32'(want.commanded_on), 32'(rsp.commanded_on));
                check_field("phase_active", 32'(want.phase_active), 32'(rsp.phase_active));
                check_field("fault", 32'(want.fault), 32'(rsp.fault));
                check_field("load_present", 32'(want.load_present), 32'(rsp.load_present));
            end
            words_checked++;
            if (rsp.drive_level == LEVEL_FULL)
                full_drive_seen++;
            if (rsp.drive_level == LEVEL_SOFT)
                soft_drive_seen++;
            if (!rsp.load_present)
                load_lost_seen++;
            if (rsp.fault)
                fault_seen++;
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            rx_wait = rx_burst ? 0 : $urandom_range(0, 9);
        end
        else if (rx_wait != 0)
            rx_wait--;
        rsp_stall <= (rx_wait != 0);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("pump_retry_sequencer_with_load_check test failed");
            $finish;
        end
    end

    initial
    begin
        int i;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening table under reset register values
        for (i = 0; i < 25; i++)
            send_word(opening_rows[i].func, opening_rows[i].adc, opening_rows[i].typed,
                      opening_rows[i].status);
        drain();

        // threshold extremes, limit past the schedule end saturates
        program_regs(1023, 0, 0, 7, 31);
        run_pump(150, 15, 1'b1);
        drain();

        program_regs(0, 1023, 7, 0, 25);
        run_pump(150, 15, 1'b1);
        drain();

        // mid thresholds, frequent restarts
        program_regs(300, 150, 2, 3, 20);
        run_pump(200, 25, 1'b1);
        drain();

        // one long clean run through kick, soft start, rest and full drive
        // until the retry limit trips the sticky fault
        program_regs(600, 300, 1, 1, 4);
        run_pump(860, 2, 1'b0);
        drain();

        // fault must survive off / on, zero limit written last
        program_regs(175, 40, 5, 5, 0);
        run_pump(40, 30, 1'b1);
        drain();
        repeat (4) @(posedge clk);

        $display("run covered %0d words in, %0d status words checked", words_sent,
                 words_checked);
        $display("full drive %0d, soft drive %0d, load lost %0d, with fault %0d",
                 full_drive_seen, soft_drive_seen, load_lost_seen, fault_seen);
        if (errors == 0)
            $display("pump_retry_sequencer_with_load_check test passed");
        else
            $display("pump_retry_sequencer_with_load_check test failed");
        $finish;
    end

endmodule

// ----- pump_retry_sequencer_with_load_check.f -----
src/pmp_pkg.sv
src/pmp_core.sv
src/pump_retry_sequencer_with_load_check.sv
test/pump_retry_sequencer_with_load_check_tb.sv
